[rtl/rdmpp_pkg.sv]
`default_nettype none
package rdmpp_pkg;

  localparam int PosW = 9;
  localparam int UidW = 48;
  localparam int MinLength = 24;
  localparam logic [7:0] LeadCodeRst = 8'd204;
  localparam logic [7:0] SubCodeRst = 8'd1;

  typedef enum logic {
    CFG_LEAD_CODE = 1'b0,
    CFG_SUB_CODE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_START        = 3'd1,
    ST_SUB_START    = 3'd2,
    ST_SHORT_LENGTH = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_TRUNCATED    = 3'd5,
    ST_CHECKSUM     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] lead_code;
    logic [7:0] sub_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } byte_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      data_byte;
    status_e         status;
    logic [UidW-1:0] dst_uid;
    logic [UidW-1:0] src_uid;
    logic [7:0]      transaction_number;
    logic [7:0]      port_id;
    logic [7:0]      message_count;
    logic [15:0]     subdev;
    logic [7:0]      command_class;
    logic [15:0]     parameter_id;
    logic [7:0]      param_length;
  } res_t;

endpackage
`default_nettype wire

[rtl/rdmpp_if.sv]
`default_nettype none
interface rdmpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte_in;
  logic       frame_start;
  logic       buffer_end;

  modport source (output valid, data_byte_in, frame_start, buffer_end, input ready);
  modport sink (input valid, data_byte_in, frame_start, buffer_end, output ready);
endinterface

interface rdmpp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte_out;
  logic [2:0]  status;
  logic [47:0] dst_uid;
  logic [47:0] src_uid;
  logic [7:0]  transaction_number;
  logic [7:0]  port_id;
  logic [7:0]  message_count;
  logic [15:0] subdev;
  logic [7:0]  command_class;
  logic [15:0] parameter_id;
  logic [7:0]  param_length;

  modport source (output valid, kind, data_byte_out, status, dst_uid, src_uid,
                  transaction_number, port_id, message_count, subdev,
                  command_class, parameter_id, param_length, input ready);
  modport sink (input valid, kind, data_byte_out, status, dst_uid, src_uid,
                transaction_number, port_id, message_count, subdev,
                command_class, parameter_id, param_length, output ready);
endinterface
`default_nettype wire

[rtl/rdmpp_parse.sv]
`default_nettype none
module rdmpp_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  rdmpp_pkg::cfg_t  cfg_i,
  input  rdmpp_pkg::byte_t item_i,
  output logic            res_valid_o,
  output rdmpp_pkg::res_t  res_o
);
  import rdmpp_pkg::*;

  logic [PosW-1:0] pos_q, pos_e, pos_d;
  logic            done_q, done_e, done_d;
  logic [7:0]      ml_q, ml_e, ml_d;
  logic [15:0]     sum_q, sum_e, sum_d;
  logic [7:0]      csh_q, csh_e, csh_d;
  logic [UidW-1:0] dest_q, dest_e, dest_d;
  logic [UidW-1:0] src_q, src_e, src_d;
  logic [7:0]      tn_q, tn_e, tn_d;
  logic [7:0]      port_q, port_e, port_d;
  logic [7:0]      mc_q, mc_e, mc_d;
  logic [15:0]     subdev_q, subdev_e, subdev_d;
  logic [7:0]      cc_q, cc_e, cc_d;
  logic [15:0]     pid_q, pid_e, pid_d;
  logic [7:0]      plen_q, plen_e, plen_d;

  logic            fail, fin, data_out, verdict, upd;
  status_e         status;
  logic [7:0]      b;
  logic [PosW-1:0] ml_ext;

  assign b      = item_i.data;
  assign ml_ext = PosW'(ml_e);

  // frame start clears the frame before the byte is taken
  always_comb begin
    if (item_i.start) begin
      pos_e    = '0;
      done_e   = 1'b0;
      ml_e     = '0;
      sum_e    = '0;
      csh_e    = '0;
      dest_e   = '0;
      src_e    = '0;
      tn_e     = '0;
      port_e   = '0;
      mc_e     = '0;
      subdev_e = '0;
      cc_e     = '0;
      pid_e    = '0;
      plen_e   = '0;
    end else begin
      pos_e    = pos_q;
      done_e   = done_q;
      ml_e     = ml_q;
      sum_e    = sum_q;
      csh_e    = csh_q;
      dest_e   = dest_q;
      src_e    = src_q;
      tn_e     = tn_q;
      port_e   = port_q;
      mc_e     = mc_q;
      subdev_e = subdev_q;
      cc_e     = cc_q;
      pid_e    = pid_q;
      plen_e   = plen_q;
    end
  end

  always_comb begin
    ml_d     = ml_e;
    csh_d    = csh_e;
    dest_d   = dest_e;
    src_d    = src_e;
    tn_d     = tn_e;
    port_d   = port_e;
    mc_d     = mc_e;
    subdev_d = subdev_e;
    cc_d     = cc_e;
    pid_d    = pid_e;
    plen_d   = plen_e;
    fail     = 1'b0;
    fin      = 1'b0;
    data_out = 1'b0;
    status   = ST_OK;
    pos_d    = pos_e + PosW'(1);

    if (pos_e < PosW'(3) || pos_e < ml_ext) begin
      sum_d = sum_e + 16'(b);
    end else begin
      sum_d = sum_e;
    end

    if (pos_e == PosW'(0)) begin
      if (b != cfg_i.lead_code) begin
        fail   = 1'b1;
        status = ST_START;
      end
    end else if (pos_e == PosW'(1)) begin
      if (b != cfg_i.sub_code) begin
        fail   = 1'b1;
        status = ST_SUB_START;
      end
    end else if (pos_e == PosW'(2)) begin
      ml_d = b;
      if (b < 8'(MinLength)) begin
        fail   = 1'b1;
        status = ST_SHORT_LENGTH;
      end
    end else if (pos_e <= PosW'(8)) begin
      dest_d = {dest_e[UidW-9:0], b};
    end else if (pos_e <= PosW'(14)) begin
      src_d = {src_e[UidW-9:0], b};
    end else if (pos_e == PosW'(15)) begin
      tn_d = b;
    end else if (pos_e == PosW'(16)) begin
      port_d = b;
    end else if (pos_e == PosW'(17)) begin
      mc_d = b;
    end else if (pos_e <= PosW'(19)) begin
      subdev_d = {subdev_e[7:0], b};
    end else if (pos_e == PosW'(20)) begin
      cc_d = b;
    end else if (pos_e <= PosW'(22)) begin
      pid_d = {pid_e[7:0], b};
    end else if (pos_e == PosW'(23)) begin
      plen_d = b;
      if (ml_ext != PosW'(MinLength) + PosW'(b)) begin
        fail   = 1'b1;
        status = ST_LEN_MISMATCH;
      end
    end else if (pos_e < ml_ext) begin
      data_out = 1'b1;
    end else if (pos_e == ml_ext) begin
      csh_d = b;
    end else begin
      fin    = 1'b1;
      status = ({csh_e, b} == sum_e) ? ST_OK : ST_CHECKSUM;
    end

    if (!fail && !fin && item_i.last) begin
      status = ST_TRUNCATED;
    end
  end

  assign verdict     = fail || fin || item_i.last;
  assign res_valid_o = !done_e && (verdict || data_out);
  assign done_d      = done_e || verdict;
  assign upd         = step_i && !done_e;

  always_comb begin
    res_o = '0;
    if (verdict) begin
      res_o.kind               = 1'b1;
      res_o.status             = status;
      res_o.dst_uid            = dest_d;
      res_o.src_uid            = src_d;
      res_o.transaction_number = tn_d;
      res_o.port_id            = port_d;
      res_o.message_count      = mc_d;
      res_o.subdev             = subdev_d;
      res_o.command_class      = cc_d;
      res_o.parameter_id       = pid_d;
      res_o.param_length       = plen_d;
    end else begin
      res_o.data_byte = b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      done_q   <= 1'b1;
      ml_q     <= '0;
      sum_q    <= '0;
      csh_q    <= '0;
      dest_q   <= '0;
      src_q    <= '0;
      tn_q     <= '0;
      port_q   <= '0;
      mc_q     <= '0;
      subdev_q <= '0;
      cc_q     <= '0;
      pid_q    <= '0;
      plen_q   <= '0;
    end else if (upd) begin
      pos_q    <= pos_d;
      done_q   <= done_d;
      ml_q     <= ml_d;
      sum_q    <= sum_d;
      csh_q    <= csh_d;
      dest_q   <= dest_d;
      src_q    <= src_d;
      tn_q     <= tn_d;
      port_q   <= port_d;
      mc_q     <= mc_d;
      subdev_q <= subdev_d;
      cc_q     <= cc_d;
      pid_q    <= pid_d;
      plen_q   <= plen_d;
    end
  end

endmodule
`default_nettype wire

[rtl/rdm_packet_parser_core.sv]
`default_nettype none
// RDM frame parser, one byte per transfer.
// Flow: a byte is registered in the input stage, parsed there, and its result
//   goes into the output register when the input stage advances.
// Throughput: one byte per cycle if output is free; sum and header update bound it.
// Reset: asynchronous, active low; parser waits for a frame start, codes go to 204 and 1.
module rdm_packet_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  rdmpp_in_if.sink    byte_i,
  rdmpp_out_if.source result_o
);
  import rdmpp_pkg::*;

  cfg_t   cfg_q;
  logic   s1_valid_q;
  byte_t  s1_q;
  logic   out_valid_q;
  res_t   res_q;
  logic   s1_adv, out_free, pres_valid;
  res_t   pres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_code <= LeadCodeRst;
      cfg_q.sub_code  <= SubCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEAD_CODE: cfg_q.lead_code <= cfg_wdata_i;
        CFG_SUB_CODE:  cfg_q.sub_code  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && (!pres_valid || out_free);
  assign byte_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      s1_q.data  <= byte_i.data_byte_in;
      s1_q.start <= byte_i.frame_start;
      s1_q.last  <= byte_i.buffer_end;
    end
  end

  rdmpp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .cfg_i       (cfg_q),
    .item_i      (s1_q),
    .res_valid_o (pres_valid),
    .res_o       (pres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && pres_valid) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && pres_valid) begin
      res_q <= pres;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.kind               = res_q.kind;
  assign result_o.data_byte_out      = res_q.data_byte;
  assign result_o.status             = 3'(res_q.status);
  assign result_o.dst_uid            = res_q.dst_uid;
  assign result_o.src_uid            = res_q.src_uid;
  assign result_o.transaction_number = res_q.transaction_number;
  assign result_o.port_id            = res_q.port_id;
  assign result_o.message_count      = res_q.message_count;
  assign result_o.subdev             = res_q.subdev;
  assign result_o.command_class      = res_q.command_class;
  assign result_o.parameter_id       = res_q.parameter_id;
  assign result_o.param_length       = res_q.param_length;

`ifndef ASSERT_OFF
  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && pres_valid) |=> out_valid_q)
    else $error("parsed result not captured in output register");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stalled input stage lost its byte");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.kind) |-> (res_q.status == ST_OK && res_q.dst_uid == '0
                                      && res_q.param_length == '0))
    else $error("data byte result carries header fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !(s1_adv && pres_valid))
    else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire

[tb/sv/rdm_packet_parser_core_test.sv]
module rdm_packet_parser_core_test;
  import rdmpp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int QuietCycles = 8;

  typedef enum int {FL_NONE, FL_START, FL_SUB, FL_SHORT, FL_LEN, FL_SUM} flaw_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_wdata_i;

  rdmpp_in_if  byte_if ();
  rdmpp_out_if result_if ();

  rdm_packet_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_if),
    .result_o    (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame parser state
  logic [7:0]      cfg_code_start;
  logic [7:0]      cfg_code_sub;
  logic [PosW-1:0] frm_pos;
  bit              frm_idle;
  logic [7:0]      frm_len;
  logic [15:0]     frm_sum;
  logic [7:0]      frm_cs_hi;
  logic [UidW-1:0] frm_dest;
  logic [UidW-1:0] frm_src;
  logic [7:0]      frm_hdr [5];
  logic [15:0]     frm_subdev;
  logic [15:0]     frm_pid;

  byte_t       byte_q[$];
  byte_t       on_bus;
  res_t        parsed_q[$];
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned mismatches;
  int unsigned cycles;
  int          in_gap;
  int          out_gap;
  bit          gaps_on;
  bit          drv_hit;
  res_t        drv_res;
  res_t        mon_seen;
  res_t        mon_want;

  task automatic frm_clear();
    frm_pos = '0;
    frm_len = '0;
    frm_sum = '0;
    frm_cs_hi = '0;
    frm_dest = '0;
    frm_src = '0;
    foreach (frm_hdr[i]) frm_hdr[i] = '0;
    frm_subdev = '0;
    frm_pid = '0;
  endtask

  function automatic res_t frame_verdict(input status_e st);
    res_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    r.dst_uid = frm_dest;
    r.src_uid = frm_src;
    r.transaction_number = frm_hdr[0];
    r.port_id = frm_hdr[1];
    r.message_count = frm_hdr[2];
    r.subdev = frm_subdev;
    r.command_class = frm_hdr[3];
    r.parameter_id = frm_pid;
    r.param_length = frm_hdr[4];
    return r;
  endfunction

  task automatic parse_byte(input byte_t in, output bit got, output res_t r);
    logic [PosW-1:0] pos;
    logic [7:0]      len;
    bit              fail;
    bit              pdata;
    status_e         st;
    got = 1'b0;
    r = '0;
    fail = 1'b0;
    pdata = 1'b0;
    st = ST_OK;
    if (in.start) begin
      frm_clear();
      frm_idle = 1'b0;
    end
    if (!frm_idle) begin
      pos = frm_pos;
      len = frm_len;
      if (pos < 3 || pos < len) frm_sum = frm_sum + in.data;
      if (pos == 0) begin
        if (in.data != cfg_code_start) begin
          fail = 1'b1;
          st = ST_START;
        end
      end else if (pos == 1) begin
        if (in.data != cfg_code_sub) begin
          fail = 1'b1;
          st = ST_SUB_START;
        end
      end else if (pos == 2) begin
        frm_len = in.data;
        if (in.data < MinLength) begin
          fail = 1'b1;
          st = ST_SHORT_LENGTH;
        end
      end else if (pos <= 8) begin
        frm_dest = {frm_dest[UidW-9:0], in.data};
      end else if (pos <= 14) begin
        frm_src = {frm_src[UidW-9:0], in.data};
      end else if (pos <= 17) begin
        frm_hdr[pos-15] = in.data;
      end else if (pos <= 19) begin
        frm_subdev = {frm_subdev[7:0], in.data};
      end else if (pos == 20) begin
        frm_hdr[3] = in.data;
      end else if (pos <= 22) begin
        frm_pid = {frm_pid[7:0], in.data};
      end else if (pos == 23) begin
        frm_hdr[4] = in.data;
        if (int'(len) != MinLength + int'(in.data)) begin
          fail = 1'b1;
          st = ST_LEN_MISMATCH;
        end
      end else if (pos < len) begin
        pdata = 1'b1;
      end else if (pos == len) begin
        frm_cs_hi = in.data;
      end else begin
        fail = 1'b1;
        st = ({frm_cs_hi, in.data} == frm_sum) ? ST_OK : ST_CHECKSUM;
      end
      if (fail) begin
        r = frame_verdict(st);
        frm_idle = 1'b1;
        got = 1'b1;
      end else begin
        frm_pos = pos + 1'b1;
        if (in.last) begin
          r = frame_verdict(ST_TRUNCATED);
          frm_idle = 1'b1;
          got = 1'b1;
        end else if (pdata) begin
          r.data_byte = in.data;
          got = 1'b1;
        end
      end
    end
  endtask

  function automatic string res_str(input res_t r);
    return $sformatf({"kind=%0d data=%h st=%0d dst=%h src=%h tn=%h port=%h cnt=%h",
                      " sub=%h cc=%h pid=%h len=%h"},
                     r.kind, r.data_byte, r.status, r.dst_uid, r.src_uid,
                     r.transaction_number, r.port_id, r.message_count, r.subdev,
                     r.command_class, r.parameter_id, r.param_length);
  endfunction

  task automatic report(input string what, input res_t want, input res_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  want %s", res_str(want));
      $display("  got  %s", res_str(seen));
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
      byte_if.data_byte_in <= '0;
      byte_if.frame_start <= 1'b0;
      byte_if.buffer_end <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        parse_byte(on_bus, drv_hit, drv_res);
        if (drv_hit) parsed_q.push_back(drv_res);
        bytes_taken++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          byte_if.valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          on_bus = byte_q.pop_front();
          byte_if.valid <= 1'b1;
          byte_if.data_byte_in <= on_bus.data;
          byte_if.frame_start <= on_bus.start;
          byte_if.buffer_end <= on_bus.last;
          if (gaps_on && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 19);
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        mon_seen.kind = result_if.kind;
        mon_seen.data_byte = result_if.data_byte_out;
        mon_seen.status = status_e'(result_if.status);
        mon_seen.dst_uid = result_if.dst_uid;
        mon_seen.src_uid = result_if.src_uid;
        mon_seen.transaction_number = result_if.transaction_number;
        mon_seen.port_id = result_if.port_id;
        mon_seen.message_count = result_if.message_count;
        mon_seen.subdev = result_if.subdev;
        mon_seen.command_class = result_if.command_class;
        mon_seen.parameter_id = result_if.parameter_id;
        mon_seen.param_length = result_if.param_length;
        if (parsed_q.size() == 0) begin
          report("unexpected result", '0, mon_seen);
        end else begin
          mon_want = parsed_q.pop_front();
          if (mon_seen !== mon_want) report("result mismatch", mon_want, mon_seen);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] d, input bit s, input bit l);
    byte_t b;
    b.data = d;
    b.start = s;
    b.last = l;
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  // fill: 0 all zero, 1 all ones, else random header and data
  task automatic add_frame(input int plen, input flaw_e flaw, input int cut, input bit mark,
                           input int fill);
    logic [7:0]  fr[$];
    logic [15:0] sum;
    logic [7:0]  v;
    int          total;
    int          n;
    int          fail_at;
    fr.push_back(cfg_code_start);
    fr.push_back(cfg_code_sub);
    fr.push_back(8'(MinLength + plen));
    for (int i = 3; i < 23; i++) begin
      v = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      fr.push_back(v);
    end
    fr.push_back(8'(plen));
    for (int i = 0; i < plen; i++) begin
      v = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      fr.push_back(v);
    end
    sum = '0;
    foreach (fr[i]) sum = sum + fr[i];
    fail_at = plen + 25;
    case (flaw)
      FL_START: begin
        fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
        fail_at = 0;
      end
      FL_SUB: begin
        fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
        fail_at = 1;
      end
      FL_SHORT: begin
        fr[2] = 8'($urandom_range(0, MinLength - 1));
        fail_at = 2;
      end
      FL_LEN: begin
        fr[23] = fr[23] ^ 8'($urandom_range(1, 255));
        fail_at = 23;
      end
      FL_SUM: sum = sum ^ 16'($urandom_range(1, 65535));
      default: ;
    endcase
    fr.push_back(sum[15:8]);
    fr.push_back(sum[7:0]);
    total = fr.size();
    if (flaw != FL_NONE) begin
      n = fail_at + 1 + $urandom_range(0, 2);
    end else if (cut > 0) begin
      n = cut;
    end else begin
      n = total;
    end
    if (n > total) n = total;
    for (int i = 0; i < n; i++) push_byte(fr[i], i == 0, mark && i == n - 1);
    if (flaw == FL_NONE && cut == 0) begin
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0,
                                              1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_frames(input int unsigned n_bytes, input bit allow_gaps);
    int unsigned target;
    int          pick;
    int          plen;
    int          fill;
    int          lsel;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) begin
      while (byte_q.size() > 48) @(posedge clk_i);
      if (!allow_gaps) begin
        gaps_on = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        gaps_on = !gaps_on;
      end
      lsel = $urandom_range(0, 19);
      if (lsel < 16) begin
        plen = $urandom_range(0, 6);
      end else if (lsel < 19) begin
        plen = $urandom_range(7, 40);
      end else begin
        plen = $urandom_range(200, 231);
      end
      pick = $urandom_range(0, 99);
      fill = $urandom_range(0, 9);
      if (pick < 55) begin
        add_frame(plen, FL_NONE, 0, $urandom_range(0, 3) == 0, fill);
      end else if (pick < 60) begin
        add_frame(plen, FL_START, 0, 1'($urandom_range(0, 1)), fill);
      end else if (pick < 65) begin
        add_frame(plen, FL_SUB, 0, 1'($urandom_range(0, 1)), fill);
      end else if (pick < 70) begin
        add_frame(plen, FL_SHORT, 0, 1'($urandom_range(0, 1)), fill);
      end else if (pick < 75) begin
        add_frame(plen, FL_LEN, 0, 1'($urandom_range(0, 1)), fill);
      end else if (pick < 82) begin
        add_frame(plen, FL_SUM, 0, 1'($urandom_range(0, 1)), fill);
      end else if (pick < 94) begin
        add_frame(plen, FL_NONE, $urandom_range(1, plen + 25), $urandom_range(0, 4) != 0, fill);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LEAD_CODE) begin
      cfg_code_start = val;
    end else begin
      cfg_code_sub = val;
    end
  endtask

  task automatic wait_quiet();
    while (bytes_taken != bytes_queued || parsed_q.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_LEAD_CODE;
    cfg_wdata_i <= '0;
    cfg_code_start = LeadCodeRst;
    cfg_code_sub = SubCodeRst;
    frm_clear();
    frm_idle = 1'b1;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bad start code together with buffer end
    push_byte(8'h00, 1'b1, 1'b1);
    // idle byte
    push_byte(8'hFF, 1'b0, 1'b0);
    // bad sub start code
    push_byte(LeadCodeRst, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // short length with buffer end
    push_byte(LeadCodeRst, 1'b1, 1'b0);
    push_byte(SubCodeRst, 1'b0, 1'b0);
    push_byte(8'd23, 1'b0, 1'b1);
    // buffer ends on byte 0
    push_byte(LeadCodeRst, 1'b1, 1'b1);
    // frame cut off by a new frame start
    push_byte(LeadCodeRst, 1'b1, 1'b0);
    push_byte(SubCodeRst, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    add_frame(0, FL_NONE, 0, 1'b1, 1);
    wait_quiet();

    write_cfg(CFG_LEAD_CODE, 8'h00);
    write_cfg(CFG_SUB_CODE, 8'hFF);
    random_frames(400, 1'b1);
    wait_quiet();

    write_cfg(CFG_LEAD_CODE, 8'hFF);
    write_cfg(CFG_SUB_CODE, 8'h00);
    random_frames(400, 1'b1);
    wait_quiet();

    write_cfg(CFG_LEAD_CODE, 8'($urandom_range(0, 255)));
    write_cfg(CFG_SUB_CODE, 8'($urandom_range(0, 255)));
    random_frames(600, 1'b1);
    wait_quiet();

    write_cfg(CFG_LEAD_CODE, LeadCodeRst);
    write_cfg(CFG_SUB_CODE, SubCodeRst);
    random_frames(500, 1'b0);
    wait_quiet();

    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
